### hdl/integer_to_radix_digits_macros.svh
// Assertion macros shared by the integer_to_radix_digits RTL
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ITRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ITRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/itrd_pkg.sv
// Types and constants of the integer to radix digit converter
package itrd_pkg;

  localparam int unsigned VALUE_W         = 31;
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned DIGIT_W         = 6;
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned DIV_STEPS       = VALUE_W;
  localparam int unsigned CNT_W           = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_WAIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic pop_rd;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_ok;
    logic div_last;
    logic quo_zero;
    logic sp_zero;
    logic out_free;
  } sts_t;

endpackage

### hdl/itrd_ram.sv
// Generic single-write, single-read RAM with registered read data
module itrd_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/itrd_ctrl.sv
// Sequencer: divide, push, pop and emit control for the digit converter
`include "integer_to_radix_digits_macros.svh"

module itrd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  itrd_pkg::sts_t sts_i,
  output itrd_pkg::cmd_t cmd_o
);

  itrd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itrd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      itrd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // zero value or radix below two: drop the beat
          if (sts_i.in_ok) begin
            state_d = itrd_pkg::ST_DIV;
          end
        end
      end
      itrd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = itrd_pkg::ST_PUSH;
        end
      end
      itrd_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = sts_i.quo_zero ? itrd_pkg::ST_POP_RD : itrd_pkg::ST_DIV;
      end
      itrd_pkg::ST_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = itrd_pkg::ST_POP_WAIT;
      end
      itrd_pkg::ST_POP_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.sp_zero ? itrd_pkg::ST_IDLE : itrd_pkg::ST_POP_RD;
        end
      end
      default: begin
        state_d = itrd_pkg::ST_IDLE;
      end
    endcase
  end

  `ITRD_ASSERT_SAME(a_idle_stack_empty, state_q == itrd_pkg::ST_IDLE, sts_i.sp_zero, "stack not empty between items")
  `ITRD_ASSERT_NEXT(a_div_runs, state_q == itrd_pkg::ST_DIV && !sts_i.div_last, state_q == itrd_pkg::ST_DIV, "division left early")

endmodule

### hdl/itrd_dp.sv
// Datapath: bit-serial divider, digit stack and output register
`include "integer_to_radix_digits_macros.svh"

module itrd_dp #(
  parameter int unsigned STACK_DEPTH = itrd_pkg::STACK_DEPTH_DEF,
  localparam int unsigned SPW        = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW         = $clog2(STACK_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itrd_pkg::in_t  in_data_i,
  input  itrd_pkg::cmd_t cmd_i,
  output itrd_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output itrd_pkg::out_t out_data_o
);

  logic [itrd_pkg::VALUE_W-1:0] dq_q, dq_d;
  logic [itrd_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [itrd_pkg::DIGIT_W-1:0] rem_q, rem_d;
  logic [itrd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [SPW-1:0]               sp_q, sp_d, sp_m1;
  logic                         out_valid_q, out_valid_d;
  itrd_pkg::out_t               out_q, out_d;

  logic [itrd_pkg::DIGIT_W:0]   trial;
  logic                         ge;
  logic                         push_ok;
  logic [itrd_pkg::DIGIT_W-1:0] rd_digit;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_q, dq_q[itrd_pkg::VALUE_W-1]};
  assign ge      = trial >= {1'b0, radix_q};
  assign sp_m1   = sp_q - 1'b1;
  assign push_ok = sp_q < SPW'(STACK_DEPTH);

  always_comb begin
    dq_d        = dq_q;
    radix_d     = radix_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    sp_d        = sp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cmd_i.load) begin
      dq_d    = in_data_i.value;
      radix_d = in_data_i.radix;
      rem_d   = '0;
      cnt_d   = '0;
      sp_d    = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = ge ? itrd_pkg::DIGIT_W'(trial - {1'b0, radix_q})
                 : trial[itrd_pkg::DIGIT_W-1:0];
      dq_d  = {dq_q[itrd_pkg::VALUE_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.push) begin
      rem_d = '0;
      cnt_d = '0;
      if (push_ok) begin
        sp_d = sp_q + 1'b1;
      end
    end
    if (cmd_i.pop_rd) begin
      sp_d = sp_m1;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_d.digit = rd_digit;
      out_d.last  = (sp_q == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    radix_q <= radix_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  itrd_ram #(
    .WIDTH (itrd_pkg::DIGIT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && push_ok),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (rem_q),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (sp_m1[AW-1:0]),
    .rdata_o (rd_digit)
  );

  assign sts_o.in_ok    = (in_data_i.value != '0) &&
                          (in_data_i.radix > itrd_pkg::RADIX_W'(1));
  assign sts_o.div_last = cnt_q == itrd_pkg::CNT_W'(itrd_pkg::DIV_STEPS - 1);
  assign sts_o.quo_zero = dq_q == '0;
  assign sts_o.sp_zero  = sp_q == '0;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ITRD_ASSERT(a_sp_bound, sp_q <= SPW'(STACK_DEPTH), "stack pointer past depth")
  `ITRD_ASSERT_SAME(a_rem_below_radix, cmd_i.div_step, rem_q < radix_q, "partial remainder not below radix")

endmodule

### hdl/integer_to_radix_digits.sv
// Each digit takes 31 one-bit division steps plus a stack push; the digits are then
// popped one at a time from the stack RAM (POP_RD, POP_WAIT) into the output register.
// A stalled output holds the sequencer in POP_WAIT. The next beat is taken the cycle
// after the last digit enters the output register. Zero values and radix 0 or 1
// are dropped without leaving IDLE. Reset clears sequencer, digit counter, stack
// pointer and output valid only.
module integer_to_radix_digits #(
  parameter int unsigned STACK_DEPTH = itrd_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  itrd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output itrd_pkg::out_t out_data_o
);

  itrd_pkg::cmd_t cmd;
  itrd_pkg::sts_t sts;

  itrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itrd_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
